// ===== design/assert_macros.svh =====
// Assertion macros shared by the length search modules.
// Needs a clock named clk and an active-low reset named rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CHK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== design/fsls_pkg.sv =====
// Package for the 7-smooth length search: constants, operation codes and
// the command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package fsls_pkg;

    // Default width of the requested length.
    localparam int LENGTH_BITS_DEF = 24;

    // Operation codes.
    localparam logic OP_NEXT = 1'b0;
    localparam logic OP_PREV = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the request and start the search
        logic mul7;     // next power of seven
        logic enter5;   // start the power-of-five walk from the power of seven
        logic mul5;     // next multiple by five
        logic enter3;   // start the power-of-three walk
        logic mul3;     // keep the candidate if better, then next multiple by three
        logic enter_x;  // load the doubling register from the current product
        logic dbl_x;    // double the candidate
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic p7_in;    // power of seven within the bound
        logic p75_in;   // product with fives within the bound
        logic p753_in;  // product with threes within the bound
        logic x_grow;   // candidate should be doubled once more
    } status_t;

endpackage

// ===== design/fsls_datapath.sv =====
// Datapath of the 7-smooth length search: product registers, doubling
// register and best candidate. Depends on fsls_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fsls_datapath
    import fsls_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    input  logic                   operation,
    input  logic [LENGTH_BITS-1:0] request_length,
    output status_t                status,
    output logic [LENGTH_BITS:0]   smooth_length
);

    // Products reach at most seven times the bound before they are compared.
    localparam int BOUND_BITS = LENGTH_BITS + 1;
    localparam int WORK_BITS  = LENGTH_BITS + 4;

    logic                   prev_reg;
    logic [LENGTH_BITS-1:0] n_reg;
    logic [BOUND_BITS-1:0]  lim_reg;
    logic [BOUND_BITS-1:0]  best_reg;
    logic [WORK_BITS-1:0]   p7_reg;
    logic [WORK_BITS-1:0]   p75_reg;
    logic [WORK_BITS-1:0]   p753_reg;
    logic [WORK_BITS-1:0]   x_reg;

    logic [LENGTH_BITS-1:0] n_in;
    logic [BOUND_BITS-1:0]  twice_n;
    logic [WORK_BITS-1:0]   n_ext;
    logic [WORK_BITS-1:0]   lim_ext;
    logic [WORK_BITS-1:0]   best_ext;
    logic [WORK_BITS-1:0]   x_dbl;
    logic [WORK_BITS-1:0]   p7_mul;
    logic [WORK_BITS-1:0]   p75_mul;
    logic [WORK_BITS-1:0]   p753_mul;
    logic                   x_better;

    // A zero request counts as a request of one.
    assign n_in    = (request_length == '0) ? LENGTH_BITS'(1) : request_length;
    assign twice_n = {n_in, 1'b0};

    assign n_ext    = WORK_BITS'(n_reg);
    assign lim_ext  = WORK_BITS'(lim_reg);
    assign best_ext = WORK_BITS'(best_reg);
    assign x_dbl    = {x_reg[WORK_BITS-2:0], 1'b0};

    // Constant multiplies as shift and add.
    assign p7_mul   = {p7_reg[WORK_BITS-4:0], 3'b000} - p7_reg;
    assign p75_mul  = {p75_reg[WORK_BITS-3:0], 2'b00} + p75_reg;
    assign p753_mul = {p753_reg[WORK_BITS-2:0], 1'b0} + p753_reg;

    assign status.p7_in   = (p7_reg <= lim_ext);
    assign status.p75_in  = (p75_reg <= lim_ext);
    assign status.p753_in = (p753_reg <= lim_ext);
    assign status.x_grow  = (prev_reg == OP_PREV) ? (x_dbl <= n_ext) : (x_reg < n_ext);

    assign x_better = (prev_reg == OP_PREV) ? (x_reg > best_ext) : (x_reg < best_ext);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            prev_reg <= operation;
            n_reg    <= n_in;
            p7_reg   <= WORK_BITS'(1);
            if (operation == OP_PREV)
            begin
                lim_reg  <= BOUND_BITS'(n_in);
                best_reg <= BOUND_BITS'(1);
            end
            else
            begin
                lim_reg  <= twice_n;
                best_reg <= twice_n;
            end
        end
        if (cmd.mul7)
        begin
            p7_reg <= p7_mul;
        end
        if (cmd.enter5)
        begin
            p75_reg <= p7_reg;
        end
        if (cmd.mul5)
        begin
            p75_reg <= p75_mul;
        end
        if (cmd.enter3)
        begin
            p753_reg <= p75_reg;
        end
        if (cmd.mul3)
        begin
            p753_reg <= p753_mul;
            if (x_better)
            begin
                best_reg <= x_reg[BOUND_BITS-1:0];
            end
        end
        if (cmd.enter_x)
        begin
            x_reg <= p753_reg;
        end
        if (cmd.dbl_x)
        begin
            x_reg <= x_dbl;
        end
    end

    assign smooth_length = best_reg;

    // A candidate kept in next mode lies between the request and the bound.
    `CHK_IMPLY(a_next_cand, cmd.mul3 && prev_reg == OP_NEXT,
               x_reg >= n_ext && x_reg <= lim_ext, "next-mode candidate out of range")
    // A candidate kept in prev mode is at most the request and above half of it.
    `CHK_IMPLY(a_prev_cand, cmd.mul3 && prev_reg == OP_PREV,
               x_reg <= n_ext && x_dbl > n_ext, "prev-mode candidate out of range")

endmodule

// ===== design/fsls_ctrl.sv =====
// Controller of the 7-smooth length search: walks the nested product loops
// and the doubling loop. Depends on fsls_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fsls_ctrl
    import fsls_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy,
    output logic    done
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CHK7 = 6'b000010,
        S_CHK5 = 6'b000100,
        S_CHK3 = 6'b001000,
        S_DBL  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHK7;
                end
            end
            S_CHK7:
            begin
                if (status.p7_in)
                begin
                    cmd.enter5 = 1'b1;
                    state_next = S_CHK5;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CHK5:
            begin
                if (status.p75_in)
                begin
                    cmd.enter3 = 1'b1;
                    state_next = S_CHK3;
                end
                else
                begin
                    cmd.mul7   = 1'b1;
                    state_next = S_CHK7;
                end
            end
            S_CHK3:
            begin
                if (status.p753_in)
                begin
                    cmd.enter_x = 1'b1;
                    state_next  = S_DBL;
                end
                else
                begin
                    cmd.mul5   = 1'b1;
                    state_next = S_CHK5;
                end
            end
            S_DBL:
            begin
                if (status.x_grow)
                begin
                    cmd.dbl_x = 1'b1;
                end
                else
                begin
                    cmd.mul3   = 1'b1;
                    state_next = S_CHK3;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    // An accepted request starts the search in the following cycle.
    `CHK_NEXT(a_start_busy, start && !busy, busy && !done, "request not taken up")
    // The result strobe lasts one cycle and the block is free right after.
    `CHK_NEXT(a_done_once, done, !done && !busy, "result strobe not single")

endmodule

// ===== design/fft_smooth_length_search.sv =====
// Top level of the 7-smooth transform length search.
// Depends on fsls_pkg, fsls_ctrl and fsls_datapath.
`timescale 1ns / 1ps

// Usage
// A request word (operation, request_length) is taken at a rising edge where
// start is high and busy is low. Operation next returns the smallest length
// of the form 2^a*3^b*5^c*7^d at or above the request; operation prev
// returns the largest such length at or below it. A zero request counts as one.
// The result word appears on smooth_length while done is high, for exactly
// one cycle; the receiver cannot stall it, so it must take it then.
// Search: the controller visits every product of powers of 7, 5 and 3 up to
// the bound (twice the request in next mode, the request in prev mode), tests
// each loop level in turn, and doubles each product towards the request,
// keeping the best candidate. One request is in work at a time; a new
// request is taken only after done, once busy is low again.
// Reset returns the controller to idle; no request is in work afterwards. The
// datapath registers, smooth_length among them, are not reset.

module fft_smooth_length_search
    import fsls_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   operation,
    input  logic [LENGTH_BITS-1:0] request_length,
    output logic                   done,
    output logic [LENGTH_BITS:0]   smooth_length
);

    cmd_t    cmd;
    status_t status;

    // The controller sequences the nested loops; it sees only status flags.
    fsls_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // The datapath holds the products and the best length found so far,
    // which stays on smooth_length and is valid while done is high.
    fsls_datapath #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .operation      (operation),
        .request_length (request_length),
        .status         (status),
        .smooth_length  (smooth_length)
    );

endmodule
